// ===== rtl/jra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jra_pkg
// Shared types, constants and helpers for the joint row acceleration pipeline.
// ----------------------------------------------------------------------------
package jra_pkg;

  localparam int unsigned CompW  = 20;
  localparam int unsigned VecW   = 3 * CompW;
  localparam int unsigned DenW   = 27;
  localparam int unsigned MagW   = 60;
  localparam int unsigned QuotW  = 44;
  localparam int unsigned ExtraW = 54;

  localparam logic signed [11:0] KS = 12'sd750;
  localparam logic [8:0]         KD = 9'd400;
  localparam logic [15:0]        DT_RESET = 16'd1092;

  typedef enum logic [2:0] {
    CFG_TIME_STEP  = 3'd0,
    CFG_FIRST_PASS = 3'd1,
    CFG_LIN_VEL_A  = 3'd2,
    CFG_ANG_VEL_A  = 3'd3,
    CFG_LIN_VEL_B  = 3'd4,
    CFG_ANG_VEL_B  = 3'd5,
    CFG_GYRO_A     = 3'd6,
    CFG_GYRO_B     = 3'd7
  } cfg_idx_e;

  typedef logic [VecW-1:0] vec_t;

  typedef struct packed {
    logic               is_motor;
    logic signed [31:0] motor_accel;
    logic signed [31:0] delta_accel;
    logic signed [31:0] penetration_in;
    vec_t               jac_lin_a;
    vec_t               jac_ang_a;
    vec_t               jac_lin_b;
    vec_t               jac_ang_b;
    vec_t               arm_a;
    vec_t               arm_b;
    logic               last_row_in;
  } row_in_t;

  typedef struct packed {
    logic signed [31:0] coord_accel;
    logic signed [31:0] penetration_out;
    logic               last_row_out;
  } row_out_t;

  typedef struct packed {
    logic [15:0] time_step;
    logic        first_pass;
    vec_t        lin_vel_a;
    vec_t        ang_vel_a;
    vec_t        lin_vel_b;
    vec_t        ang_vel_b;
    vec_t        gyro_a;
    vec_t        gyro_b;
  } cfg_t;

  typedef struct packed {
    logic               is_motor;
    logic               last_row;
    logic signed [31:0] delta;
    logic signed [31:0] motor_acc;
    logic signed [31:0] pen_in;
  } side_t;

  typedef struct packed {
    side_t                  side;
    logic signed [31:0]     pen;
    logic signed [ExtraW-1:0] extra;
    logic                   neg;
  } div_tag_t;

  function automatic logic signed [CompW-1:0] comp(input vec_t v, input int unsigned i);
    comp = $signed(v[CompW*i +: CompW]);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sh7FFF_FFFF) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (x < -64'sh8000_0000) begin
      sat32 = -32'sh8000_0000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

endpackage

// ===== rtl/jra_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jra_front
// Seven-stage datapath: velocity and gyro dot products, double cross products,
// penetration advance, spring-damper numerator and its magnitude.
// ----------------------------------------------------------------------------
module jra_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  jra_pkg::row_in_t            data_i,
  input  jra_pkg::cfg_t               cfg_i,
  input  logic [jra_pkg::DenW-1:0]    damp_i,
  output logic                        valid_o,
  output logic [jra_pkg::MagW-1:0]    mag_o,
  output jra_pkg::div_tag_t           tag_o
);

  localparam int unsigned I1 [3] = '{1, 2, 0};
  localparam int unsigned I2 [3] = '{2, 0, 1};

  logic [6:0] vld_q;

  // stage 1
  logic signed [39:0] vp_d [12], vp_q [12];
  logic signed [39:0] gp_d [6],  gp_q [6];
  logic signed [39:0] xa_d [3][2], xa_q [3][2];
  logic signed [39:0] xb_d [3][2], xb_q [3][2];
  jra_pkg::vec_t      jla1_q, jlb1_q;
  jra_pkg::side_t     side_d, side1_q;

  // stage 2
  logic signed [43:0] vrel24_d, vrel24_q;
  logic signed [42:0] gyro_d, gyro2_q;
  logic signed [28:0] c1a_d [3], c1a_q [3], c1b_d [3], c1b_q [3];
  jra_pkg::vec_t      jla2_q, jlb2_q;
  jra_pkg::side_t     side2_q;

  // stage 3
  logic signed [31:0] vrel_d, vrel3_q;
  logic signed [48:0] ya_d [3][2], ya_q [3][2], yb_d [3][2], yb_q [3][2];
  logic signed [42:0] gyro3_q;
  jra_pkg::vec_t      jla3_q, jlb3_q;
  jra_pkg::side_t     side3_q;

  // stage 4
  logic signed [37:0] c2a_d [3], c2a_q [3], c2b_d [3], c2b_q [3];
  logic signed [48:0] adv_d, adv_q;
  logic signed [31:0] vrel4_q;
  logic signed [42:0] gyro4_q;
  jra_pkg::vec_t      jla4_q, jlb4_q;
  jra_pkg::side_t     side4_q;

  // stage 5
  logic signed [57:0] cp_d [6], cp_q [6];
  logic signed [31:0] pen_d, pen5_q, vrel5_q;
  logic signed [42:0] gyro5_q;
  jra_pkg::side_t     side5_q;

  // stage 6
  logic signed [60:0] centr_d;
  logic signed [61:0] gdiff_d;
  logic signed [53:0] extra_d, extra6_q;
  logic signed [41:0] kspen_d;
  logic signed [57:0] numa_d, numa_q;
  logic signed [59:0] numb_d, numb_q;
  logic signed [31:0] pen6_q;
  jra_pkg::side_t     side6_q;

  // stage 7
  logic signed [60:0] num_d;
  logic               neg_d;
  logic [59:0]        mag_d, mag_q;
  jra_pkg::div_tag_t  tag_d, tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[5:0], valid_i};
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vp_d[k]   = 40'(jra_pkg::comp(data_i.jac_lin_a, k)) * 40'(jra_pkg::comp(cfg_i.lin_vel_a, k));
      vp_d[3+k] = 40'(jra_pkg::comp(data_i.jac_ang_a, k)) * 40'(jra_pkg::comp(cfg_i.ang_vel_a, k));
      vp_d[6+k] = 40'(jra_pkg::comp(data_i.jac_lin_b, k)) * 40'(jra_pkg::comp(cfg_i.lin_vel_b, k));
      vp_d[9+k] = 40'(jra_pkg::comp(data_i.jac_ang_b, k)) * 40'(jra_pkg::comp(cfg_i.ang_vel_b, k));
      gp_d[k]   = 40'(jra_pkg::comp(data_i.jac_ang_a, k)) * 40'(jra_pkg::comp(cfg_i.gyro_a, k));
      gp_d[3+k] = 40'(jra_pkg::comp(data_i.jac_ang_b, k)) * 40'(jra_pkg::comp(cfg_i.gyro_b, k));
      xa_d[k][0] = 40'(jra_pkg::comp(cfg_i.ang_vel_a, I1[k])) * 40'(jra_pkg::comp(data_i.arm_a, I2[k]));
      xa_d[k][1] = 40'(jra_pkg::comp(cfg_i.ang_vel_a, I2[k])) * 40'(jra_pkg::comp(data_i.arm_a, I1[k]));
      xb_d[k][0] = 40'(jra_pkg::comp(cfg_i.ang_vel_b, I1[k])) * 40'(jra_pkg::comp(data_i.arm_b, I2[k]));
      xb_d[k][1] = 40'(jra_pkg::comp(cfg_i.ang_vel_b, I2[k])) * 40'(jra_pkg::comp(data_i.arm_b, I1[k]));
    end
    side_d.is_motor  = data_i.is_motor;
    side_d.last_row  = data_i.last_row_in;
    side_d.delta     = data_i.delta_accel;
    side_d.pen_in    = data_i.penetration_in;
    side_d.motor_acc = jra_pkg::sat32(64'(data_i.motor_accel) + 64'(data_i.delta_accel));
  end

  always_comb begin
    logic signed [40:0] da, db;
    vrel24_d = '0;
    gyro_d   = '0;
    for (int k = 0; k < 12; k++) vrel24_d = vrel24_d + 44'(vp_q[k]);
    for (int k = 0; k < 6; k++)  gyro_d   = gyro_d + 43'(gp_q[k]);
    for (int k = 0; k < 3; k++) begin
      da = 41'(xa_q[k][0]) - 41'(xa_q[k][1]);
      db = 41'(xb_q[k][0]) - 41'(xb_q[k][1]);
      c1a_d[k] = $signed(da[40:12]);
      c1b_d[k] = $signed(db[40:12]);
    end
  end

  always_comb begin
    vrel_d = jra_pkg::sat32(64'($signed(vrel24_q[43:8])));
    for (int k = 0; k < 3; k++) begin
      ya_d[k][0] = 49'(jra_pkg::comp(cfg_i.ang_vel_a, I1[k])) * 49'(c1a_q[I2[k]]);
      ya_d[k][1] = 49'(jra_pkg::comp(cfg_i.ang_vel_a, I2[k])) * 49'(c1a_q[I1[k]]);
      yb_d[k][0] = 49'(jra_pkg::comp(cfg_i.ang_vel_b, I1[k])) * 49'(c1b_q[I2[k]]);
      yb_d[k][1] = 49'(jra_pkg::comp(cfg_i.ang_vel_b, I2[k])) * 49'(c1b_q[I1[k]]);
    end
  end

  always_comb begin
    logic signed [49:0] da, db;
    for (int k = 0; k < 3; k++) begin
      da = 50'(ya_q[k][0]) - 50'(ya_q[k][1]);
      db = 50'(yb_q[k][0]) - 50'(yb_q[k][1]);
      c2a_d[k] = $signed(da[49:12]);
      c2b_d[k] = $signed(db[49:12]);
    end
    if (cfg_i.first_pass) begin
      adv_d = 49'(vrel3_q) * 49'($signed({1'b0, cfg_i.time_step}));
    end else begin
      adv_d = '0;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cp_d[k]   = 58'(jra_pkg::comp(jla4_q, k)) * 58'(c2a_q[k]);
      cp_d[3+k] = 58'(jra_pkg::comp(jlb4_q, k)) * 58'(c2b_q[k]);
    end
    pen_d = jra_pkg::sat32(64'(side4_q.pen_in) - 64'($signed(adv_q[48:16])));
  end

  always_comb begin
    centr_d = '0;
    for (int k = 0; k < 6; k++) centr_d = centr_d + 61'(cp_q[k]);
    gdiff_d = 62'(gyro5_q) - 62'(centr_d);
    extra_d = $signed(gdiff_d[61:8]);
    kspen_d = 42'(pen5_q) * 42'(jra_pkg::KS);
    numa_d  = $signed({kspen_d, 16'h0000});
    numb_d  = 60'($signed({1'b0, damp_i})) * 60'(vrel5_q);
  end

  always_comb begin
    logic signed [60:0] abs_v;
    num_d = 61'(numa_q) - 61'(numb_q);
    neg_d = num_d[60];
    abs_v = neg_d ? -num_d : num_d;
    mag_d = abs_v[59:0];
    tag_d.side  = side6_q;
    tag_d.pen   = pen6_q;
    tag_d.extra = extra6_q;
    tag_d.neg   = neg_d;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vp_q    <= vp_d;
      gp_q    <= gp_d;
      xa_q    <= xa_d;
      xb_q    <= xb_d;
      jla1_q  <= data_i.jac_lin_a;
      jlb1_q  <= data_i.jac_lin_b;
      side1_q <= side_d;

      vrel24_q <= vrel24_d;
      gyro2_q  <= gyro_d;
      c1a_q    <= c1a_d;
      c1b_q    <= c1b_d;
      jla2_q   <= jla1_q;
      jlb2_q   <= jlb1_q;
      side2_q  <= side1_q;

      vrel3_q <= vrel_d;
      ya_q    <= ya_d;
      yb_q    <= yb_d;
      gyro3_q <= gyro2_q;
      jla3_q  <= jla2_q;
      jlb3_q  <= jlb2_q;
      side3_q <= side2_q;

      c2a_q   <= c2a_d;
      c2b_q   <= c2b_d;
      adv_q   <= adv_d;
      vrel4_q <= vrel3_q;
      gyro4_q <= gyro3_q;
      jla4_q  <= jla3_q;
      jlb4_q  <= jlb3_q;
      side4_q <= side3_q;

      cp_q    <= cp_d;
      pen5_q  <= pen_d;
      vrel5_q <= vrel4_q;
      gyro5_q <= gyro4_q;
      side5_q <= side4_q;

      extra6_q <= extra_d;
      numa_q   <= numa_d;
      numb_q   <= numb_d;
      pen6_q   <= pen5_q;
      side6_q  <= side5_q;

      mag_q <= mag_d;
      tag_q <= tag_d;
    end
  end

  assign valid_o = vld_q[6];
  assign mag_o   = mag_q;
  assign tag_o   = tag_q;

endmodule

// ===== rtl/jra_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jra_div
// Pipelined restoring divider, one quotient bit per stage, tag carried along.
// ----------------------------------------------------------------------------
module jra_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [jra_pkg::MagW-1:0]    mag_i,
  input  jra_pkg::div_tag_t           tag_i,
  input  logic [jra_pkg::DenW-1:0]    den_i,
  output logic                        valid_o,
  output logic [jra_pkg::QuotW-1:0]   quot_o,
  output jra_pkg::div_tag_t           tag_o
);

  localparam int unsigned QB = jra_pkg::QuotW;
  localparam int unsigned TW = jra_pkg::MagW + QB + 1;

  logic [QB-1:0]              vld_q;
  logic [jra_pkg::MagW-1:0]   rem_q  [QB];
  logic [QB-1:0]              quot_q [QB];
  jra_pkg::div_tag_t          tag_q  [QB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QB-2:0], valid_i};
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_stage
    localparam int unsigned Bit = QB - 1 - s;
    logic [jra_pkg::MagW-1:0] rem_in;
    logic [QB-1:0]            quot_in;
    jra_pkg::div_tag_t        tag_in;
    logic [TW-1:0]            trial;

    if (s == 0) begin : g_first
      assign rem_in  = mag_i;
      assign quot_in = '0;
      assign tag_in  = tag_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign quot_in = quot_q[s-1];
      assign tag_in  = tag_q[s-1];
    end

    assign trial = TW'(rem_in) - (TW'(den_i) << Bit);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[s] <= tag_in;
        if (!trial[TW-1]) begin
          rem_q[s]  <= trial[jra_pkg::MagW-1:0];
          quot_q[s] <= quot_in | (QB'(1) << Bit);
        end else begin
          rem_q[s]  <= rem_in;
          quot_q[s] <= quot_in;
        end
      end
    end
  end

  assign valid_o = vld_q[QB-1];
  assign quot_o  = quot_q[QB-1];
  assign tag_o   = tag_q[QB-1];

endmodule

// ===== rtl/joint_row_acceleration.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_row_acceleration
// Depth: 7 datapath stages, 44 divider stages and 1 output register between
//   request accept and result valid; the divider sets the depth.
// Throughput: one request per cycle; a stall freezes the whole pipeline.
// Reset: asynchronous active low; clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module joint_row_acceleration (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  jra_pkg::row_in_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output jra_pkg::row_out_t          out_data_o,
  input  logic                       cfg_we_i,
  input  logic [2:0]                 cfg_idx_i,
  input  logic [jra_pkg::VecW-1:0]   cfg_data_i
);

  localparam int unsigned DenW = jra_pkg::DenW;

  jra_pkg::cfg_t            cfg_q;
  logic [31:0]              dtsq_q;
  logic [jra_pkg::DenW-1:0] den_q, damp_q, den_d, damp_d;
  logic [41:0]              ksdt2_d;
  logic                     en;

  logic                     fr_valid;
  logic [jra_pkg::MagW-1:0] fr_mag;
  jra_pkg::div_tag_t        fr_tag;
  logic                     dv_valid;
  logic [jra_pkg::QuotW-1:0] dv_quot;
  jra_pkg::div_tag_t        dv_tag;

  logic                     out_valid_q;
  jra_pkg::row_out_t        out_d, out_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_step  <= jra_pkg::DT_RESET;
      cfg_q.first_pass <= 1'b0;
      cfg_q.lin_vel_a  <= '0;
      cfg_q.ang_vel_a  <= '0;
      cfg_q.lin_vel_b  <= '0;
      cfg_q.ang_vel_b  <= '0;
      cfg_q.gyro_a     <= '0;
      cfg_q.gyro_b     <= '0;
    end else if (cfg_we_i) begin
      case (jra_pkg::cfg_idx_e'(cfg_idx_i))
        jra_pkg::CFG_TIME_STEP:  cfg_q.time_step  <= cfg_data_i[15:0];
        jra_pkg::CFG_FIRST_PASS: cfg_q.first_pass <= cfg_data_i[0];
        jra_pkg::CFG_LIN_VEL_A:  cfg_q.lin_vel_a  <= cfg_data_i;
        jra_pkg::CFG_ANG_VEL_A:  cfg_q.ang_vel_a  <= cfg_data_i;
        jra_pkg::CFG_LIN_VEL_B:  cfg_q.lin_vel_b  <= cfg_data_i;
        jra_pkg::CFG_ANG_VEL_B:  cfg_q.ang_vel_b  <= cfg_data_i;
        jra_pkg::CFG_GYRO_A:     cfg_q.gyro_a     <= cfg_data_i;
        jra_pkg::CFG_GYRO_B:     cfg_q.gyro_b     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    ksdt2_d = 42'(dtsq_q) * 42'(10'd750);
    den_d   = DenW'(17'h10000) + DenW'(cfg_q.time_step) * DenW'(jra_pkg::KD)
              + DenW'(ksdt2_d[41:16]);
    damp_d  = DenW'({jra_pkg::KD, 16'h0000}) + DenW'(cfg_q.time_step) * DenW'(10'd750);
  end

  always_ff @(posedge clk_i) begin
    dtsq_q <= 32'(cfg_q.time_step) * 32'(cfg_q.time_step);
    den_q  <= den_d;
    damp_q <= damp_d;
  end

  jra_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .cfg_i   (cfg_q),
    .damp_i  (damp_q),
    .valid_o (fr_valid),
    .mag_o   (fr_mag),
    .tag_o   (fr_tag)
  );

  jra_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .mag_i   (fr_mag),
    .tag_i   (fr_tag),
    .den_i   (den_q),
    .valid_o (dv_valid),
    .quot_o  (dv_quot),
    .tag_o   (dv_tag)
  );

  always_comb begin
    logic signed [44:0] aerr;
    aerr = dv_tag.neg ? -45'(dv_quot) : 45'(dv_quot);
    out_d.last_row_out = dv_tag.side.last_row;
    if (dv_tag.side.is_motor) begin
      out_d.coord_accel     = dv_tag.side.motor_acc;
      out_d.penetration_out = dv_tag.side.pen_in;
    end else begin
      out_d.coord_accel     = jra_pkg::sat32(64'(dv_tag.side.delta) + 64'(aerr)
                                             + 64'(dv_tag.extra));
      out_d.penetration_out = dv_tag.pen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
